@@ sv/wstfd_pkg.sv @@
`default_nettype none
package wstfd_pkg;

	typedef enum logic [2:0] {
		PH_HDR0 = 3'd0,
		PH_HDR1 = 3'd1,
		PH_EXT  = 3'd2,
		PH_KEY  = 3'd3,
		PH_DATA = 3'd4
	} phase_t;

	localparam logic [3:0] OPC_TEXT    = 4'h1;
	localparam logic [6:0] LEN7_EXT16  = 7'd126;
	localparam logic [6:0] LEN7_EXT64  = 7'd127;
	localparam logic [3:0] EXT16_BYTES = 4'd2;
	localparam logic [3:0] EXT64_BYTES = 4'd8;
	localparam logic [1:0] KEY_LAST    = 2'd3;

endpackage
`default_nettype wire

@@ sv/websocket_text_frame_deframer_top.sv @@
`default_nettype none
// WebSocket text-frame deframer. Bytes of a received stream enter on s_axis one per
// transaction. A first header byte whose opcode is not text is dropped. The 7-bit, 16-bit
// or 64-bit length (kept to LENGTH_BITS bits) and the optional 4-byte mask key are parsed,
// then each payload byte leaves unmasked on m_axis, with tlast on the last byte of the
// frame. Headers and zero-length frames give no output. One byte is taken every cycle; a
// byte passes an input register and then a result register on its way to m_axis. The
// input stalls only while a result waits in the full output register and m_axis_tready
// is low.
module websocket_text_frame_deframer_top
	import wstfd_pkg::*;
#(
	parameter int LENGTH_BITS = 63
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,   // [7:0] rx_byte
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,   // [7:0] payload_byte
	output logic            m_axis_tlast    // frame_end
);

	localparam int LB = LENGTH_BITS;

	logic                  valid_s1;
	logic [7:0]            byte_s1;

	phase_t                phase_q, phase_d;
	logic                  mask_q, mask_d;
	logic [3:0]            ext_q, ext_d;
	logic [LB-1:0]         rem_q, rem_d;
	logic [31:0]           key_q, key_d;
	logic [1:0]            idx_q, idx_d;
	logic                  hdr_done;

	logic                  m_valid_q;
	logic [7:0]            m_data_q;
	logic                  m_last_q;

	logic                  out_free;
	logic                  advance;
	logic                  emit;
	logic [7:0]            key_byte;
	logic [7:0]            out_byte;
	logic                  out_last;

	assign out_free      = !m_valid_q || m_axis_tready;
	assign emit          = valid_s1 && (phase_q == PH_DATA);
	assign advance       = valid_s1 && ((phase_q != PH_DATA) || out_free);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
		end
	end

	always_comb begin
		phase_d  = phase_q;
		mask_d   = mask_q;
		ext_d    = ext_q;
		rem_d    = rem_q;
		key_d    = key_q;
		idx_d    = idx_q;
		hdr_done = 1'b0;
		unique case (phase_q)
			PH_HDR1: begin
				mask_d = byte_s1[7];
				rem_d  = '0;
				if (byte_s1[6:0] == LEN7_EXT16) begin
					ext_d   = EXT16_BYTES;
					phase_d = PH_EXT;
				end else if (byte_s1[6:0] == LEN7_EXT64) begin
					ext_d   = EXT64_BYTES;
					phase_d = PH_EXT;
				end else begin
					ext_d    = 4'd0;
					rem_d    = {{(LB-7){1'b0}}, byte_s1[6:0]};
					hdr_done = 1'b1;
				end
			end
			PH_EXT: begin
				rem_d = {rem_q[LB-9:0], byte_s1};
				if (ext_q != 4'd0) begin
					ext_d = ext_q - 4'd1;
				end
				hdr_done = (ext_d == 4'd0);
			end
			PH_KEY: begin
				key_d = {key_q[23:0], byte_s1};
				if (idx_q == KEY_LAST) begin
					idx_d   = 2'd0;
					phase_d = (rem_q == '0) ? PH_HDR0 : PH_DATA;
				end else begin
					idx_d = idx_q + 2'd1;
				end
			end
			PH_DATA: begin
				idx_d = idx_q + 2'd1;
				if (rem_q != '0) begin
					rem_d = rem_q - {{(LB-1){1'b0}}, 1'b1};
				end
				if (rem_d == '0) begin
					phase_d = PH_HDR0;
				end
			end
			default: begin
				phase_d = (byte_s1[3:0] == OPC_TEXT) ? PH_HDR1 : PH_HDR0;
			end
		endcase
		if (hdr_done) begin
			if (mask_d) begin
				idx_d   = 2'd0;
				key_d   = '0;
				phase_d = PH_KEY;
			end else if (rem_d == '0) begin
				phase_d = PH_HDR0;
			end else begin
				idx_d   = 2'd0;
				phase_d = PH_DATA;
			end
		end
	end

	always_comb begin
		unique case (idx_q)
			2'd0:    key_byte = key_q[31:24];
			2'd1:    key_byte = key_q[23:16];
			2'd2:    key_byte = key_q[15:8];
			default: key_byte = key_q[7:0];
		endcase
		out_byte = byte_s1 ^ (mask_q ? key_byte : 8'h00);
		out_last = (rem_q[LB-1:1] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HDR0;
			mask_q  <= 1'b0;
			ext_q   <= 4'd0;
			rem_q   <= '0;
			key_q   <= '0;
			idx_q   <= 2'd0;
		end else if (advance) begin
			phase_q <= phase_d;
			mask_q  <= mask_d;
			ext_q   <= ext_d;
			rem_q   <= rem_d;
			key_q   <= key_d;
			idx_q   <= idx_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (emit && out_free) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit && out_free) begin
			m_data_q <= out_byte;
			m_last_q <= out_last;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign m_axis_tlast  = m_last_q;

`ifndef SYNTHESIS
	a_rise_from_data: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_valid_q) |-> $past(phase_q == PH_DATA))
		else $error("output valid without a payload byte");

	a_key_needs_mask: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_KEY) |-> mask_q)
		else $error("mask key phase in an unmasked frame");

	a_ext_count: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_EXT) |-> (ext_q != 4'd0))
		else $error("extended length phase with no bytes left");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_axis_tready |-> (valid_s1 && m_valid_q && !m_axis_tready))
		else $error("input stalled without a blocked result");
`endif

endmodule
`default_nettype wire
